FILE: rtl/nlsg_pkg.sv
package nlsg_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned LABEL_W = 10;
  localparam int unsigned CLASS_W = 4;
  localparam int unsigned LFSR_W  = 16;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [LFSR_W-1:0]  LFSR_FALLBACK = 16'hACE1;
  localparam logic [CLASS_W-1:0] OFFSET_SPAN   = 4'd9;
  localparam logic [CLASS_W:0]   CLASS_COUNT   = 5'd10;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SEED        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLES_JOB = 2'd1;

  // result word, fields listed high bits first, as in tdata order
  typedef struct packed {
    logic                 job_last;
    logic                 sample_last;
    logic [CLASS_W-1:0]   negative_class;
    logic [CLASS_W-1:0]   true_class;
    logic [WORD_W-1:0]    negative_word;
    logic [WORD_W-1:0]    positive_word;
  } out_item_t;

  // label decode result for word 0
  typedef struct packed {
    logic [CLASS_W-1:0] true_class;
    logic [CLASS_W-1:0] negative_class;
    logic [LFSR_W-1:0]  lfsr_nxt;
    logic [WORD_W-1:0]  negative_word;
  } label_res_t;

  function automatic logic [LFSR_W-1:0] lfsr_advance(input logic [LFSR_W-1:0] s);
    logic fb;
    fb = s[0] ^ s[2] ^ s[3] ^ s[5];
    return {fb, s[LFSR_W-1:1]};
  endfunction

  function automatic logic [LFSR_W-1:0] seed_load(input logic [LFSR_W-1:0] s);
    return (s == '0) ? LFSR_FALLBACK : s;
  endfunction

  function automatic logic [CLASS_W-1:0] highest_label_bit(input logic [LABEL_W-1:0] lbl);
    logic [CLASS_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < LABEL_W; i++) begin
      if (lbl[i]) idx = CLASS_W'(i);
    end
    return idx;
  endfunction

  function automatic logic [CLASS_W-1:0] pick_negative(input logic [CLASS_W-1:0] t,
                                                       input logic [CLASS_W-1:0] r);
    logic [CLASS_W-1:0] off;
    logic [CLASS_W:0]   sum;
    off = (r >= OFFSET_SPAN) ? (r - OFFSET_SPAN) : r;
    sum = {1'b0, t} + {1'b0, off} + {{CLASS_W{1'b0}}, 1'b1};
    return (sum >= CLASS_COUNT) ? CLASS_W'(sum - CLASS_COUNT) : sum[CLASS_W-1:0];
  endfunction

endpackage

FILE: rtl/nlsg_label.sv
module nlsg_label (
  input  logic [nlsg_pkg::WORD_W-1:0] word,
  input  logic [nlsg_pkg::LFSR_W-1:0] lfsr,
  output nlsg_pkg::label_res_t        res
);
  import nlsg_pkg::*;

  logic [CLASS_W-1:0] true_c;
  logic [CLASS_W-1:0] neg_c;
  logic [LFSR_W-1:0]  lfsr_adv;
  logic [LABEL_W-1:0] neg_onehot;

  always_comb begin
    true_c     = highest_label_bit(word[LABEL_W-1:0]);
    lfsr_adv   = lfsr_advance(lfsr);
    neg_c      = pick_negative(true_c, lfsr_adv[CLASS_W-1:0]);
    neg_onehot = LABEL_W'(1) << neg_c;

    res.true_class     = true_c;
    res.negative_class = neg_c;
    res.lfsr_nxt       = lfsr_adv;
    res.negative_word  = {word[WORD_W-1:LABEL_W], neg_onehot};
  end

endmodule

FILE: rtl/nlsg_skid.sv
module nlsg_skid (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  nlsg_pkg::out_item_t   push_item,
  output logic                  ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output nlsg_pkg::out_item_t   out_item
);
  import nlsg_pkg::*;

  out_item_t main_r, main_nxt;
  out_item_t skid_r, skid_nxt;
  logic      main_vld_r, main_vld_nxt;
  logic      skid_vld_r, skid_vld_nxt;
  logic      pop;

  assign pop       = main_vld_r & out_ready;
  assign ready     = ~skid_vld_r;
  assign out_valid = main_vld_r;
  assign out_item  = main_r;

  always_comb begin
    main_nxt     = main_r;
    skid_nxt     = skid_r;
    main_vld_nxt = main_vld_r;
    skid_vld_nxt = skid_vld_r;
    if (skid_vld_r) begin
      // no push possible while skid is full
      if (pop) begin
        main_nxt     = skid_r;
        skid_vld_nxt = 1'b0;
      end
    end else if (push) begin
      if (!main_vld_r || pop) begin
        main_nxt     = push_item;
        main_vld_nxt = 1'b1;
      end else begin
        skid_nxt     = push_item;
        skid_vld_nxt = 1'b1;
      end
    end else if (pop) begin
      main_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
    if (!rst_n) begin
      main_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      main_vld_r <= main_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

endmodule

FILE: rtl/negative_label_sample_generator.sv
// Channel | Dir | Ports                                  | Word
// in      | in  | in_tvalid/in_tready/in_tdata           | one 32-bit stream word
// out     | out | out_tvalid/out_tready/out_tdata/tlast/ | positive + negative word,
//         |     | out_tuser                              | class indexes, last flags
// cfg     | in  | cfg_valid/cfg_ready/cfg_index/cfg_data | one register write
//
// One word in per cycle while in_tready is high, one result out per cycle while
// out_tready is high; the result is registered (label decode, LFSR step and
// class pick sit between the input and the output register). A two-entry buffer
// keeps in_tready high while an entry is free; it drops once both entries are full.
// Synchronous active-low reset: seed 0xACE1, one sample per job, counters zero.
// cfg_ready is always high; writes take effect at the next edge.
module negative_label_sample_generator #(
  parameter int unsigned SAMPLE_WORDS = 25
) (
  input  logic        clk,
  input  logic        rst_n,
  // in: [31:0] sample_word
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,
  // out: [31:0] positive_word, [63:32] negative_word,
  //      [67:64] true_class, [71:68] negative_class
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,
  output logic        out_tlast,   // sample_last
  // out_tuser: [0] job_last
  output logic [0:0]  out_tuser,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import nlsg_pkg::*;

  localparam int unsigned POS_W = (SAMPLE_WORDS > 1) ? $clog2(SAMPLE_WORDS) : 1;
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(SAMPLE_WORDS - 1);

  // config registers
  logic [LFSR_W-1:0]  seed_r;
  logic [COUNT_W-1:0] samples_job_r;

  // stream state
  logic [LFSR_W-1:0]  gen_r, gen_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [CLASS_W-1:0] true_r, true_nxt;
  logic [CLASS_W-1:0] negc_r, negc_nxt;
  logic [COUNT_W-1:0] cnt_r, cnt_nxt;

  logic       accept;
  logic       first_word;
  logic       last_word;
  logic       last_sample;
  logic       cfg_wr;
  label_res_t lab;
  out_item_t  item;
  out_item_t  out_item;

  assign accept     = in_tvalid & in_tready;
  assign cfg_ready  = 1'b1;
  assign cfg_wr     = cfg_valid & cfg_ready;
  assign first_word = (pos_r == '0);
  assign last_word  = (pos_r >= LAST_POS);
  assign last_sample = ((cnt_r + COUNT_W'(1)) == samples_job_r);

  nlsg_label u_label (
    .word (in_tdata),
    .lfsr (gen_r),
    .res  (lab)
  );

  always_comb begin
    true_nxt = first_word ? lab.true_class : true_r;
    negc_nxt = first_word ? lab.negative_class : negc_r;

    item.positive_word  = in_tdata;
    item.negative_word  = first_word ? lab.negative_word : in_tdata;
    item.true_class     = true_nxt;
    item.negative_class = negc_nxt;
    item.sample_last    = last_word;
    item.job_last       = last_word & last_sample;
  end

  // state advance on each accepted word; job end or seed write reloads the LFSR
  always_comb begin
    gen_nxt = gen_r;
    pos_nxt = pos_r;
    cnt_nxt = cnt_r;
    if (accept) begin
      if (first_word) gen_nxt = lab.lfsr_nxt;
      if (last_word) begin
        pos_nxt = '0;
        if (last_sample) begin
          cnt_nxt = '0;
          gen_nxt = seed_load(seed_r);
        end else begin
          cnt_nxt = cnt_r + COUNT_W'(1);
        end
      end else begin
        pos_nxt = pos_r + POS_W'(1);
      end
    end
    if (cfg_wr && cfg_index == REG_SEED) gen_nxt = seed_load(cfg_data);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r        <= LFSR_FALLBACK;
      samples_job_r <= COUNT_W'(1);
      gen_r         <= LFSR_FALLBACK;
      pos_r         <= '0;
      true_r        <= '0;
      negc_r        <= '0;
      cnt_r         <= '0;
    end else begin
      if (cfg_wr) begin
        unique case (cfg_index)
          REG_SEED:        seed_r        <= cfg_data;
          REG_SAMPLES_JOB: samples_job_r <= cfg_data;
          default: ;
        endcase
      end
      gen_r <= gen_nxt;
      pos_r <= pos_nxt;
      cnt_r <= cnt_nxt;
      if (accept) begin
        true_r <= true_nxt;
        negc_r <= negc_nxt;
      end
    end
  end

  nlsg_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_item (item),
    .ready     (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_item  (out_item)
  );

  assign out_tdata = {out_item.negative_class, out_item.true_class,
                      out_item.negative_word, out_item.positive_word};
  assign out_tlast = out_item.sample_last;
  assign out_tuser = out_item.job_last;

  // a job can only end on a sample boundary
  a_job_last_on_sample_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (!out_tuser[0] || out_tlast))
    else $error("job_last without sample_last");

  // the generated class never equals the true class
  a_neg_differs: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[71:68] != out_tdata[67:64]))
    else $error("negative class equals true class");

  a_neg_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[71:68] <= 4'd9))
    else $error("negative class out of range");

  // input backpressure only when the output side holds a word
  a_stall_has_data: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with empty output");

endmodule

FILE: sim/negative_label_sample_generator_tb.sv
module negative_label_sample_generator_tb;
  import nlsg_pkg::*;

  localparam int unsigned SAMPLE_WORDS = 25;
  localparam int unsigned ITEM_TARGET  = 2000;
  localparam int unsigned DRAIN_CYCLES = 4;       // block output is registered
  localparam int unsigned RUN_LIMIT    = 3000000; // time units
  localparam int unsigned MAX_REPORTS  = 30;

  // receiver back-pressure styles
  typedef enum logic [1:0] {
    RX_OPEN,
    RX_RANDOM,
    RX_PERIODIC,
    RX_SPARSE
  } rx_style_t;

  // Predicts the positive/negative word pair for every accepted stream word.
  class neg_label_predictor;
    logic [15:0] seed_reg;
    logic [15:0] job_len_reg;
    logic [15:0] lfsr;
    logic [15:0] sample_cnt;
    logic [3:0]  true_cls;
    logic [3:0]  neg_cls;
    int unsigned word_pos;
    out_item_t   expected_pairs[$];
    int unsigned errors;
    int unsigned checked;
    int unsigned job_ends;

    function new();
      seed_reg    = LFSR_FALLBACK;
      job_len_reg = 16'd1;
      lfsr        = LFSR_FALLBACK;
      sample_cnt  = '0;
      true_cls    = '0;
      neg_cls     = '0;
      word_pos    = 0;
      errors      = 0;
      checked     = 0;
      job_ends    = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
      if (idx == REG_SEED) begin
        seed_reg = val;
        lfsr     = (val == '0) ? LFSR_FALLBACK : val;
      end else if (idx == REG_SAMPLES_JOB) begin
        job_len_reg = val;
      end
    endfunction

    function int unsigned pending();
      return expected_pairs.size();
    endfunction

    function void note_input(logic [31:0] word);
      out_item_t   exp_item;
      int          b;
      int unsigned pick;
      bit          end_of_sample;
      bit          end_of_job;
      exp_item.positive_word = word;
      exp_item.negative_word = word;
      if (word_pos == 0) begin
        // top set label bit wins; an empty label falls through to class 0
        b = 9;
        while (b > 0 && !word[b]) b--;
        true_cls = b[3:0];
        lfsr = {lfsr[0] ^ lfsr[2] ^ lfsr[3] ^ lfsr[5], lfsr[15:1]};
        pick = true_cls + (lfsr[3:0] % OFFSET_SPAN) + 1;
        if (pick >= CLASS_COUNT) pick -= CLASS_COUNT;
        neg_cls = pick[3:0];
        exp_item.negative_word[9:0] = 10'b1 << pick;
      end
      end_of_sample = (word_pos == SAMPLE_WORDS - 1);
      end_of_job    = end_of_sample && (16'(sample_cnt + 16'd1) == job_len_reg);
      exp_item.true_class     = true_cls;
      exp_item.negative_class = neg_cls;
      exp_item.sample_last    = end_of_sample;
      exp_item.job_last       = end_of_job;
      expected_pairs.push_back(exp_item);
      if (end_of_sample) begin
        word_pos = 0;
        if (end_of_job) begin
          sample_cnt = '0;
          lfsr       = (seed_reg == '0) ? LFSR_FALLBACK : seed_reg;
        end else begin
          sample_cnt = sample_cnt + 16'd1;
        end
      end else begin
        word_pos++;
      end
    endfunction

    function void diff(string field, logic [31:0] want, logic [31:0] seen);
      if (want !== seen) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, seen);
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_pairs.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected result, expected none, got %h", $time, got);
        return;
      end
      want = expected_pairs.pop_front();
      checked++;
      if (got.job_last === 1'b1) job_ends++;
      diff("positive_word", want.positive_word, got.positive_word);
      diff("negative_word", want.negative_word, got.negative_word);
      diff("true_class", 32'(want.true_class), 32'(got.true_class));
      diff("negative_class", 32'(want.negative_class), 32'(got.negative_class));
      diff("sample_last", 32'(want.sample_last), 32'(got.sample_last));
      diff("job_last", 32'(want.job_last), 32'(got.job_last));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;        // pos word, neg word, true class, neg class
  logic        out_tlast;        // sample_last
  logic [0:0]  out_tuser;        // job_last
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  neg_label_predictor sb;

  // sender / receiver pacing
  int unsigned burst_left = 0;
  int unsigned stim_pos = 0;     // word position of the next word we send
  int unsigned words_sent = 0;
  int unsigned rx_tick = 0;
  rx_style_t   rx_style = RX_OPEN;

  always #6 clk = ~clk;

  negative_label_sample_generator #(
    .SAMPLE_WORDS(SAMPLE_WORDS)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Monitors: sampled at the edge, so they see pre-edge values only.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_input(in_tdata);
    if (rst_n && out_tvalid && out_tready)
      sb.check_result({out_tuser[0], out_tlast, out_tdata});
  end

  // Receiver: changes stall style on rx_tick boundaries; open style gives clean runs.
  always @(posedge clk) begin
    rx_tick <= rx_tick + 1;
    if (rx_tick % 256 == 0) rx_style <= rx_style_t'($urandom_range(0, 3));
    case (rx_style)
      RX_OPEN:     out_tready <= 1'b1;
      RX_RANDOM:   out_tready <= ($urandom_range(0, 9) > 2);
      RX_PERIODIC: out_tready <= (rx_tick % 3 != 0);
      default:     out_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // Stream word for the current position; label field only matters at word 0.
  function automatic logic [31:0] make_word(int unsigned pos);
    logic [31:0] w;
    w = $urandom();
    case ($urandom_range(0, 9))
      0: w = '0;
      1: w = '1;
      default: ;
    endcase
    if (pos == 0) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: w[9:0] = 10'b1 << $urandom_range(0, 9);
        6:       w[9:0] = '0;             // no label bit
        7:       w[9:0] = '1;             // every label bit
        default: w[9:0] = 10'($urandom_range(0, 1023));
      endcase
    end
    return w;
  endfunction

  // Push one word; bursts of random length separated by random idle gaps.
  task automatic send_word(input logic [31:0] w);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 48);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= w;
    do @(posedge clk); while (!in_tready);
    stim_pos = (stim_pos == SAMPLE_WORDS - 1) ? 0 : stim_pos + 1;
    words_sent++;
  endtask

  task automatic program_regs(input bit wr_seed, input logic [15:0] seed_v,
                              input bit wr_job, input logic [15:0] job_v);
    if (wr_seed) begin
      cfg_valid <= 1'b1;
      cfg_index <= REG_SEED;
      cfg_data  <= seed_v;
      do @(posedge clk); while (!cfg_ready);
      sb.write_reg(REG_SEED, seed_v);
    end
    if (wr_job) begin
      cfg_valid <= 1'b1;
      cfg_index <= REG_SAMPLES_JOB;
      cfg_data  <= job_v;
      do @(posedge clk); while (!cfg_ready);
      sb.write_reg(REG_SAMPLES_JOB, job_v);
    end
    cfg_valid <= 1'b0;
  endtask

  // Wait for every expected word, then DRAIN_CYCLES more so nothing is in flight.
  // The first edge lets the monitor log a word accepted at the calling edge.
  task automatic drain();
    in_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    int unsigned phase;
    int unsigned n_words;
    logic [31:0] directed_words[8];
    sb = new();
    directed_words = '{32'hFFFF_FE00, 32'h0000_0000, 32'hFFFF_FFFF, 32'hAAAA_AAAA,
                       32'h5555_5555, 32'h0000_0001, 32'h8000_0000, 32'h7FFF_FFFE};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (phase = 0; words_sent < ITEM_TARGET; phase++) begin
      drain();
      n_words = $urandom_range(20, 150);
      case (phase)
        0: n_words = SAMPLE_WORDS;                       // reset defaults
        1: program_regs(1'b1, 16'h0000, 1'b1, 16'd2);    // zero seed -> fallback
        2: begin
          program_regs(1'b1, 16'hFFFF, 1'b1, 16'hFFFF);
          n_words = 150;
        end
        3: begin
          program_regs(1'b0, '0, 1'b1, 16'h0000);        // 65536-sample job
          n_words = 80;
        end
        4: program_regs(1'b1, 16'($urandom()), 1'b1, sb.sample_cnt + 16'd2);
        5: begin
          // long job so the count climbs past one before lowering it
          program_regs(1'b0, '0, 1'b1, sb.sample_cnt + 16'd40);
          n_words = 100;
        end
        6: begin
          program_regs(1'b0, '0, 1'b1, 16'd1);           // below current count
          n_words = 40;
        end
        default: begin
          // keep the job length ahead of the count so jobs keep closing
          program_regs($urandom_range(0, 1), 16'($urandom()), 1'b1,
                       sb.sample_cnt + 16'($urandom_range(1, 4)));
        end
      endcase
      for (int unsigned k = 0; k < n_words; k++) begin
        if (phase == 0)
          send_word((k < 8) ? directed_words[k] : make_word(stim_pos));
        else
          send_word(make_word(stim_pos));
      end
    end
    drain();

    $display("covered %0d phases of register settings, %0d stream words checked",
             phase, sb.checked);
    $display("%0d job ends observed, %0d errors", sb.job_ends, sb.errors);
    if (sb.errors == 0) begin
      $display("negative_label_sample_generator regression: pass");
    end else begin
      $display("negative_label_sample_generator regression: fail");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #(RUN_LIMIT);
    $display("timeout waiting on the block");
    $display("negative_label_sample_generator regression: fail");
    $finish;
  end

endmodule
